FILE: rtl/core/lspi_pkg.sv
// Shared constants, codes and the request record of the looping sample player.
// No dependencies; every other file of the block but the sample RAM imports this package.
package lspi_pkg;

  // Sizes
  localparam int MAX_FRAMES = 65536;
  localparam int CHANNELS   = 2;
  localparam int FRAC_BITS  = 16;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int TOTAL_W    = ADDR_W + 1;

  // Field widths
  localparam int OPCODE_W   = 3;
  localparam int LOAD_AW    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int WORD_W     = 2 * SAMPLE_W;
  localparam int FRAME_W    = 17;
  localparam int RATE_W     = 24;
  localparam int OFFSET_W   = 16;
  localparam int POS_INT_W  = FRAME_W + 1;
  localparam int POS_W      = POS_INT_W + FRAC_BITS;
  localparam int SUM_W      = POS_INT_W + 1;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;

  // Rate step is 8.16; rescale to the position's fraction width
  localparam int STEP_UP    = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int STEP_DOWN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LAST   = 3'd6;

  // Command codes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PLAY  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PAUSE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SEEK  = 3'd5;

  // Memory access and sideband for one request, sent from control to the datapath
  typedef struct packed {
    logic                 tick;
    logic                 load;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_word;
    logic [ADDR_W-1:0]    rd_addr_a;
    logic [ADDR_W-1:0]    rd_addr_b;
    logic                 audible;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAME_W-1:0]   frame_index;
    logic                 playing;
  } req_t;

endpackage

FILE: rtl/core/lspi_in_if.sv
// Request channel of the sample player: valid/ready plus the command fields.
// Depends on lspi_pkg for field widths.
interface lspi_in_if;
  import lspi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [LOAD_AW-1:0]         load_address;
  logic signed [SAMPLE_W-1:0] load_left;
  logic signed [SAMPLE_W-1:0] load_right;
  logic [FRAME_W-1:0]         seek_frame;

  modport source (
    output valid, opcode, load_address, load_left, load_right, seek_frame,
    input  ready
  );

  modport sink (
    input  valid, opcode, load_address, load_left, load_right, seek_frame,
    output ready
  );

endinterface

FILE: rtl/core/lspi_out_if.sv
// Result channel of the sample player: valid/ready plus one stereo output frame.
// Depends on lspi_pkg for field widths.
interface lspi_out_if;
  import lspi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic [FRAME_W-1:0]         frame_index;
  logic                       is_playing;

  modport source (
    output valid, left_out, right_out, frame_index, is_playing,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out, frame_index, is_playing,
    output ready
  );

endinterface

FILE: rtl/core/lspi_sample_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module lspi_sample_ram #(
  parameter int ADDR_W = 16,
  parameter int WIDTH  = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [0:(2**ADDR_W)-1];

  // Write one frame
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two frames, hold the data otherwise
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/lspi_ctrl.sv
// Control front end: configuration registers, play position and run flag,
// command decode and sample address generation. Depends on lspi_pkg, lspi_in_if.
module lspi_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  lspi_in_if.sink                       in_chan,
  input  logic                          cfg_we,
  input  logic [lspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspi_pkg::CFG_DATA_W-1:0] cfg_data,
  output lspi_pkg::req_t                req
);
  import lspi_pkg::*;

  // Configuration registers
  logic [RATE_W-1:0]   rate_step;
  logic [TOTAL_W-1:0]  clip_frames;
  logic [OFFSET_W-1:0] trim_start;
  logic [OFFSET_W-1:0] padding_frames;
  logic                loop_enable;
  logic [FRAME_W-1:0]  loop_first;
  logic [FRAME_W-1:0]  loop_last;

  // Derived terms; total_c and len_s are combinational, the rest registered
  logic [TOTAL_W-1:0]         total_c;
  logic signed [SUM_W-1:0]    len_s;
  logic [FRAME_W-1:0]         len;
  logic                       total_zero;
  logic [ADDR_W-1:0]          total_m1;
  logic signed [POS_INT_W-1:0] trim_off;
  logic signed [POS_INT_W-1:0] trim_off1;
  logic                       settle;

  // Play state
  logic [POS_W-1:0] pos;
  logic             running;

  // Tick evaluation
  logic                 acc;
  logic [POS_INT_W-1:0] idx_cur;
  logic                 active;
  logic                 hit;
  logic                 wrap;
  logic                 stop_end;
  logic                 play;
  logic [POS_W-1:0]     base;
  logic [POS_W-1:0]     step_scaled;
  logic [POS_W-1:0]     adv_pos;
  logic [POS_W-1:0]     pos_after;
  logic [FRAME_W-1:0]   seek_clamped;

  // First stage
  logic                 s1_tick;
  logic                 s1_load;
  logic                 s1_play;
  logic [FRAME_W-1:0]   s1_idx;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [POS_INT_W-1:0] s1_frame;
  logic                 s1_playing;
  logic [ADDR_W-1:0]    s1_addr;
  logic [WORD_W-1:0]    s1_word;

  // Second stage
  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;
  logic                    at_end;
  req_t                    req_next;

  assign acc           = in_chan.valid && in_chan.ready;
  assign in_chan.ready = adv && !settle;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step      <= RATE_W'(65536);
      clip_frames    <= TOTAL_W'(65536);
      trim_start     <= '0;
      padding_frames <= '0;
      loop_enable    <= 1'b0;
      loop_first     <= '0;
      loop_last      <= FRAME_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RATE_STEP:   rate_step      <= cfg_data[RATE_W-1:0];
        CFG_CLIP_FRAMES: clip_frames    <= cfg_data[TOTAL_W-1:0];
        CFG_TRIM_START:  trim_start     <= cfg_data[OFFSET_W-1:0];
        CFG_PADDING:     padding_frames <= cfg_data[OFFSET_W-1:0];
        CFG_LOOP_ENABLE: loop_enable    <= cfg_data[0];
        CFG_LOOP_FIRST:  loop_first     <= cfg_data[FRAME_W-1:0];
        CFG_LOOP_LAST:   loop_last      <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Derive clip length, effective length and address offsets
  always_comb begin
    total_c = (clip_frames > TOTAL_W'(MAX_FRAMES)) ? TOTAL_W'(MAX_FRAMES) : clip_frames;
    len_s   = $signed(SUM_W'(total_c)) - $signed(SUM_W'(trim_start))
            + $signed(SUM_W'(padding_frames));
  end

  always_ff @(posedge clk) begin
    len        <= len_s[SUM_W-1] ? '0 : len_s[FRAME_W-1:0];
    total_zero <= (total_c == '0);
    total_m1   <= ADDR_W'(total_c - TOTAL_W'(1));
    trim_off   <= $signed(POS_INT_W'(trim_start)) - $signed(POS_INT_W'(padding_frames));
    trim_off1  <= $signed(POS_INT_W'(trim_start)) - $signed(POS_INT_W'(padding_frames))
                + $signed(POS_INT_W'(1));
  end

  // Hold requests in the cycle after a configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_we;
    end
  end

  // Evaluate a tick against the current position
  always_comb begin
    idx_cur      = pos[POS_W-1:FRAC_BITS];
    active       = running && !total_zero;
    hit          = (idx_cur >= POS_INT_W'(len))
                || (loop_enable && (idx_cur >= POS_INT_W'(loop_last)));
    wrap         = active && hit && loop_enable;
    stop_end     = active && hit && !loop_enable;
    play         = active && !stop_end;
    base         = wrap ? {1'b0, loop_first, {FRAC_BITS{1'b0}}} : pos;
    step_scaled  = (POS_W'(rate_step) << STEP_UP) >> STEP_DOWN;
    adv_pos      = base + step_scaled;
    pos_after    = play ? adv_pos : pos;
    seek_clamped = (in_chan.seek_frame > len) ? len : in_chan.seek_frame;
  end

  // Update position and run flag on each command
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      running <= 1'b0;
    end else if (acc) begin
      unique case (in_chan.opcode)
        OP_TICK: begin
          pos <= pos_after;
          if (stop_end) begin
            running <= 1'b0;
          end
        end
        OP_PLAY:  running <= 1'b1;
        OP_PAUSE: running <= 1'b0;
        OP_STOP: begin
          running <= 1'b0;
          pos     <= '0;
        end
        OP_SEEK:  pos <= {1'b0, seek_clamped, {FRAC_BITS{1'b0}}};
        default: ;
      endcase
    end
  end

  // Advance the first stage: ticks and in-range loads travel on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tick <= 1'b0;
      s1_load <= 1'b0;
    end else if (adv) begin
      s1_tick <= acc && (in_chan.opcode == OP_TICK);
      s1_load <= acc && (in_chan.opcode == OP_LOAD)
              && ((LOAD_AW + 1)'(in_chan.load_address) < (LOAD_AW + 1)'(MAX_FRAMES));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_play    <= play;
      s1_idx     <= base[POS_W-2:FRAC_BITS];
      s1_frac    <= base[FRAC_BITS-1:0];
      s1_frame   <= pos_after[POS_W-1:FRAC_BITS];
      s1_playing <= running && !stop_end;
      s1_addr    <= ADDR_W'(in_chan.load_address);
      s1_word    <= {in_chan.load_right, in_chan.load_left};
    end
  end

  // Clip addresses of the two neighbor frames, clamped to the clip
  always_comb begin
    sum_a  = $signed(SUM_W'(s1_idx)) + SUM_W'(trim_off);
    sum_b  = $signed(SUM_W'(s1_idx)) + SUM_W'(trim_off1);
    at_end = sum_a >= $signed(SUM_W'(total_m1));

    req_next.tick        = s1_tick;
    req_next.load        = s1_load;
    req_next.wr_addr     = s1_addr;
    req_next.wr_word     = s1_word;
    req_next.rd_addr_a   = at_end ? total_m1 : sum_a[ADDR_W-1:0];
    req_next.rd_addr_b   = at_end ? total_m1 : sum_b[ADDR_W-1:0];
    req_next.audible     = s1_play && (s1_idx >= FRAME_W'(padding_frames));
    req_next.frac        = s1_frac;
    req_next.frame_index = (s1_frame > POS_INT_W'(len)) ? len : s1_frame[FRAME_W-1:0];
    req_next.playing     = s1_playing;
  end

  // Advance the second stage, clear its request flags on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      req.tick <= 1'b0;
      req.load <= 1'b0;
    end else if (adv) begin
      req <= req_next;
    end
  end

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    acc && (in_chan.opcode == OP_STOP) |=> (pos == '0) && !running)
    else $error("stop did not clear position and run flag");

  a_play_sets: assert property (@(posedge clk) disable iff (rst)
    acc && (in_chan.opcode == OP_PLAY) |=> running)
    else $error("play did not set run flag");

  a_seek_whole: assert property (@(posedge clk) disable iff (rst)
    acc && (in_chan.opcode == OP_SEEK) |=> (pos[FRAC_BITS-1:0] == '0))
    else $error("seek left a fraction in the position");

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    $past(cfg_we) |-> !acc)
    else $error("request taken right after a configuration write");

  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    req.tick && req.audible |->
      (req.rd_addr_b == req.rd_addr_a) || (req.rd_addr_b == ADDR_W'(req.rd_addr_a + 1'b1)))
    else $error("interpolation frames are not adjacent");

endmodule

FILE: rtl/core/lspi_interp.sv
// Interpolation back end: difference times fraction, truncating add, output
// register. Depends on lspi_pkg and lspi_out_if; reads data from the sample RAM.
module lspi_interp (
  input  logic                        clk,
  input  logic                        rst,
  input  lspi_pkg::req_t              req,
  input  logic [lspi_pkg::WORD_W-1:0] rdata_a,
  input  logic [lspi_pkg::WORD_W-1:0] rdata_b,
  output logic                        adv,
  lspi_out_if.source                  out_chan
);
  import lspi_pkg::*;

  localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((2 ** FRAC_BITS) - 1);

  // Stage aligned with the RAM read data
  logic                 s3_tick;
  logic                 s3_audible;
  logic [FRAC_BITS-1:0] s3_frac;
  logic [FRAME_W-1:0]   s3_frame;
  logic                 s3_playing;

  // Product stage
  logic                       s4_tick;
  logic                       s4_audible;
  logic [FRAME_W-1:0]         s4_frame;
  logic                       s4_playing;
  logic signed [SAMPLE_W-1:0] s4_base_l;
  logic signed [SAMPLE_W-1:0] s4_base_r;
  logic signed [PROD_W-1:0]   s4_prod_l;
  logic signed [PROD_W-1:0]   s4_prod_r;

  logic signed [SAMPLE_W-1:0] a_l;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [DIFF_W-1:0]   diff_l;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [PROD_W-1:0]   frac_s;
  logic signed [PROD_W-1:0]   prod_l;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   quot_l;
  logic signed [PROD_W-1:0]   quot_r;
  logic signed [PROD_W-1:0]   sum_l;
  logic signed [PROD_W-1:0]   sum_r;

  // Whole pipe moves when the output register is free or being taken
  assign adv = !out_chan.valid || out_chan.ready;

  // Carry the sideband alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tick <= 1'b0;
    end else if (adv) begin
      s3_tick <= req.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_audible <= req.audible;
      s3_frac    <= req.frac;
      s3_frame   <= req.frame_index;
      s3_playing <= req.playing;
    end
  end

  // Multiply the neighbor difference by the fraction
  always_comb begin
    a_l    = $signed(rdata_a[SAMPLE_W-1:0]);
    a_r    = $signed(rdata_a[WORD_W-1:SAMPLE_W]);
    diff_l = DIFF_W'($signed(rdata_b[SAMPLE_W-1:0])) - DIFF_W'(a_l);
    diff_r = DIFF_W'($signed(rdata_b[WORD_W-1:SAMPLE_W])) - DIFF_W'(a_r);
    frac_s = $signed(PROD_W'(s3_frac));
    prod_l = PROD_W'(diff_l) * frac_s;
    prod_r = PROD_W'(diff_r) * frac_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tick <= 1'b0;
    end else if (adv) begin
      s4_tick <= s3_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_audible <= s3_audible;
      s4_frame   <= s3_frame;
      s4_playing <= s3_playing;
      s4_base_l  <= a_l;
      s4_base_r  <= a_r;
      s4_prod_l  <= prod_l;
      s4_prod_r  <= prod_r;
    end
  end

  // Scale down truncating toward zero, then add the base sample
  always_comb begin
    quot_l = (s4_prod_l + (s4_prod_l[PROD_W-1] ? BIAS : PROD_W'(0))) >>> FRAC_BITS;
    quot_r = (s4_prod_r + (s4_prod_r[PROD_W-1] ? BIAS : PROD_W'(0))) >>> FRAC_BITS;
    sum_l  = PROD_W'(s4_base_l) + quot_l;
    sum_r  = PROD_W'(s4_base_r) + quot_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (adv) begin
      out_chan.valid <= s4_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan.left_out    <= s4_audible ? sum_l[SAMPLE_W-1:0] : '0;
      out_chan.right_out   <= (s4_audible && (CHANNELS >= 2)) ? sum_r[SAMPLE_W-1:0] : '0;
      out_chan.frame_index <= s4_frame;
      out_chan.is_playing  <= s4_playing;
    end
  end

endmodule

FILE: rtl/core/looping_sample_player_with_interpolation.sv
// Top level of the looping stereo sample player with linear interpolation.
// Depends on lspi_pkg, lspi_in_if, lspi_out_if, lspi_ctrl, lspi_sample_ram, lspi_interp.
//
//   channel    dir  handshake        carries
//   in_chan    in   valid / ready    opcode, load_address, load_left/right, seek_frame
//   out_chan   out  valid / ready    left_out, right_out, frame_index, is_playing
//   cfg        in   cfg_we           cfg_index, cfg_data (seven registers)
//
// One request is taken per cycle while ready is high; a tick's frame passes the
// first stage, request register, RAM read stage and product stage to the output
// register. Two read ports fetch both neighbor frames at once, and loads write the
// RAM in the same stage, so loads and ticks stay in order. The position is updated
// in the cycle a tick is taken. The whole pipe holds while the output register is
// full and not taken; ready drops then, after reset and after each configuration write.
// Sample memory contents are undefined after reset; no clearing pass is run.
module looping_sample_player_with_interpolation (
  input  logic                            clk,
  input  logic                            rst,
  lspi_in_if.sink                         in_chan,
  lspi_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [lspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lspi_pkg::*;

  logic              adv;
  req_t              req;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  // Command decode, position state, address generation
  lspi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req)
  );

  // Sample memory: load writes and tick reads share one stage
  lspi_sample_ram #(
    .ADDR_W (ADDR_W),
    .WIDTH  (WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (adv && req.load),
    .waddr   (req.wr_addr),
    .wdata   (req.wr_word),
    .re      (adv && req.tick),
    .raddr_a (req.rd_addr_a),
    .raddr_b (req.rd_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Interpolation and output register
  lspi_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .adv      (adv),
    .out_chan (out_chan)
  );

endmodule
